>>> design/mvs_pkg.sv
// Package for the memory value scanner: payload types, register indexes,
// value type codes and reset constants. No dependencies.
package mvs_pkg;

    localparam int COUNT_BITS = 11;

    localparam logic [31:0] START_ADDRESS = 32'h0800_0000;
    localparam logic [10:0] DEFAULT_LIMIT = 11'd1001;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        T_U8  = 2'd0,
        T_U16 = 2'd1,
        T_U32 = 2'd2,
        T_F32 = 2'd3
    } t_value_type;

    typedef enum logic [2:0] {
        REG_VALUE_TYPE   = 3'd0,
        REG_MATCH_VALUE  = 3'd1,
        REG_USE_RANGE    = 3'd2,
        REG_RANGE_LOWER  = 3'd3,
        REG_RANGE_UPPER  = 3'd4,
        REG_BASE_ADDRESS = 3'd5,
        REG_RESULT_LIMIT = 3'd6,
        REG_UNUSED       = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] match_address;
        logic        is_match;
        logic        scan_done;
        logic        limit_reached;
    } t_out_item;

    // Compare settings handed to the compare unit
    typedef struct packed {
        t_value_type value_type;
        logic [31:0] match_value;
        logic        use_range;
        logic [31:0] range_lower;
        logic [31:0] range_upper;
    } t_cmp_cfg;

endpackage

>>> design/memory_value_search_top.sv
// Top level of the memory value scanner: configuration registers, scan state
// and the registered result stage. Depends on mvs_pkg and mvs_compare.
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle, set by the single compare and count stage,
// except while the output register holds a result under stall; input stalls
// only then. Reset clears scan state and loads register defaults (base
// 0x08000000, limit 1001).
module memory_value_search_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mvs_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output mvs_pkg::t_out_item  o_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import mvs_pkg::*;

    t_cmp_cfg r_cmp;
    logic [31:0] r_base;
    logic [10:0] r_limit;

    logic [23:0]           r_window;
    logic [31:0]           r_seen;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_stopped;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  accept;
    logic                  cmp_hit;
    logic                  hit;
    logic [COUNT_BITS-1:0] n_count;
    logic                  n_stopped;
    logic [10:0]           lim;
    logic [31:0]           back;
    logic                  emit;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp   <= '0;
            r_base  <= START_ADDRESS;
            r_limit <= DEFAULT_LIMIT;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_VALUE_TYPE:   r_cmp.value_type  <= t_value_type'(i_cfg_data[1:0]);
                REG_MATCH_VALUE:  r_cmp.match_value <= i_cfg_data;
                REG_USE_RANGE:    r_cmp.use_range   <= i_cfg_data[0];
                REG_RANGE_LOWER:  r_cmp.range_lower <= i_cfg_data;
                REG_RANGE_UPPER:  r_cmp.range_upper <= i_cfg_data;
                REG_BASE_ADDRESS: r_base            <= i_cfg_data;
                REG_RESULT_LIMIT: r_limit           <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    mvs_compare u_cmp (
        .i_cfg    (r_cmp),
        .i_window (r_window),
        .i_byte   (i_item.data_byte),
        .i_seen   (r_seen),
        .o_hit    (cmp_hit)
    );

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign hit     = cmp_hit && !r_stopped;
    assign emit    = hit || i_item.last_byte;

    // Count matches, decide the stop and pick the address offset for the type
    always_comb begin
        lim       = (r_limit == 11'd0) ? 11'd1 : r_limit;
        n_count   = r_count;
        n_stopped = r_stopped;
        if (hit) begin
            if (r_count != COUNT_MAX)
                n_count = r_count + COUNT_BITS'(1);
            if ((32'(n_count) >= 32'(lim)) || (n_count == COUNT_MAX))
                n_stopped = 1'b1;
        end
        unique case (r_cmp.value_type)
            T_U8:    back = 32'd0;
            T_U16:   back = 32'd1;
            default: back = 32'd3;
        endcase
    end

    // Advance scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= '0;
            r_seen    <= '0;
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else if (accept) begin
            if (i_item.last_byte) begin
                r_window  <= '0;
                r_seen    <= '0;
                r_count   <= '0;
                r_stopped <= 1'b0;
            end else begin
                r_window  <= (r_seen == 32'hFFFF_FFFF) ? 24'd0
                             : {r_window[15:0], i_item.data_byte};
                r_seen    <= r_seen + 32'd1;
                r_count   <= n_count;
                r_stopped <= n_stopped;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_stall) begin
            r_out_valid <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out.match_address <= hit ? (r_base + r_seen - back) : 32'd0;
            r_out.is_match      <= hit;
            r_out.scan_done     <= i_item.last_byte;
            r_out.limit_reached <= n_stopped;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // A stalled result must not be replaced
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("result changed under stall");

    // A reported address is nonzero only on a match
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.is_match) |-> (o_item.match_address == 32'd0))
        else $error("address without match");

    // Scan state clears after a last byte
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.last_byte) |=> (r_seen == 32'd0 && !r_stopped))
        else $error("scan state not cleared");

endmodule

>>> design/mvs_compare.sv
// Value compare for the memory value scanner: integer and float32 tests of
// the value that ends at the current byte. Depends on mvs_pkg.
module mvs_compare (
    input  mvs_pkg::t_cmp_cfg i_cfg,
    input  logic [23:0]       i_window,
    input  logic [7:0]        i_byte,
    input  logic [31:0]       i_seen,
    output logic              o_hit
);
    import mvs_pkg::*;

    logic [31:0] v;
    logic        lo_le_hi;
    logic        v_ge_lo;
    logic        v_lt_hi;
    logic        v_le_lo;
    logic        v_gt_hi;
    logic        f_hit;

    // NaN: exponent all ones, mantissa nonzero
    function automatic logic is_nan(input logic [31:0] a);
        is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    // a < b for non-NaN floats, with -0 == +0
    function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
        logic both_zero;
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (both_zero)
            f_lt = 1'b0;
        else if (a[31] != b[31])
            f_lt = a[31];
        else if (!a[31])
            f_lt = a[30:0] < b[30:0];
        else
            f_lt = a[30:0] > b[30:0];
    endfunction

    function automatic logic f_eq(input logic [31:0] a, input logic [31:0] b);
        f_eq = (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
    endfunction

    assign v = {i_byte, i_window[7:0], i_window[15:8], i_window[23:16]};

    // Float tests; NaN on either side fails every compare
    always_comb begin
        lo_le_hi = !f_lt(i_cfg.range_upper, i_cfg.range_lower);
        v_ge_lo  = !f_lt(v, i_cfg.range_lower);
        v_lt_hi  = f_lt(v, i_cfg.range_upper);
        v_le_lo  = !f_lt(i_cfg.range_lower, v);
        v_gt_hi  = f_lt(i_cfg.range_upper, v);
        if (is_nan(v)) begin
            f_hit = 1'b0;
        end else if (!i_cfg.use_range) begin
            f_hit = !is_nan(i_cfg.match_value) && f_eq(v, i_cfg.match_value);
        end else if (is_nan(i_cfg.range_lower) || is_nan(i_cfg.range_upper)) begin
            f_hit = 1'b0;
        end else if (lo_le_hi) begin
            f_hit = v_ge_lo && v_lt_hi;
        end else begin
            f_hit = v_le_lo && v_gt_hi;
        end
    end

    // Pick the test for the configured type
    always_comb begin
        unique case (i_cfg.value_type)
            T_U8:  o_hit = i_byte == i_cfg.match_value[7:0];
            T_U16: o_hit = (i_seen != 32'd0)
                        && ({i_byte, i_window[7:0]} == i_cfg.match_value[15:0]);
            T_U32: o_hit = (i_seen >= 32'd3) && (v == i_cfg.match_value);
            default: o_hit = (i_seen >= 32'd3) && f_hit;
        endcase
    end

endmodule
